// ----- rtl/rle_row_channel_encoder_macros.svh -----
// Assertion macros used by the encoder module.
`ifndef RLE_ROW_CHANNEL_ENCODER_MACROS_SVH
`define RLE_ROW_CHANNEL_ENCODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RLERC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rlerc check failed");

// The consequent must hold in the cycle after the antecedent.
`define RLERC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rlerc check failed");

`endif

// ----- rtl/rlerc_pkg.sv -----
package rlerc_pkg;

    // Default depth of the sample store.
    localparam int DEFAULT_MAX_WIDTH = 4096;

    // Packet format constants.
    localparam logic [6:0] MAX_COUNT    = 7'd127;
    localparam logic [7:0] LITERAL_FLAG = 8'h80;
    localparam logic [6:0] MIN_RUN      = 7'd3;

    // Input operation codes.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Where the reader stands inside the encoded stream.
    typedef enum logic [1:0] {
        PH_HEADER    = 2'd0,
        PH_RUN_VALUE = 2'd1,
        PH_LITERAL   = 2'd2,
        PH_DONE      = 2'd3
    } phase_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_FETCH = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    // One sample returned by the store during a header scan.
    typedef struct packed {
        logic       valid;
        logic [7:0] offset;
        logic       last;
        logic [7:0] data;
    } scan_arr_t;

    // Outcome of a header scan.
    typedef struct packed {
        logic       done;
        logic       is_run;
        logic [6:0] count;
    } scan_dec_t;

endpackage

// ----- rtl/rle_row_channel_encoder.sv -----
// Run-length encoder for one channel byte of a row of pixels.
// A packet value byte is produced in steps: read issue, store data, result.
// A packet header scans the store one sample a cycle, examining at most 130 samples;
// the rate is set by the single read port of the sample store.
// Reset (rst_n, asynchronous, active low) empties the row and clears all control state;
// the sample store is not cleared and needs no clearing pass.
`include "rle_row_channel_encoder_macros.svh"

module rle_row_channel_encoder
    import rlerc_pkg::*;
#(
    parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,      // channel_select
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,     // pixel
    input  logic [1:0]  s_axis_tuser,     // opcode, start_row
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,     // out_byte
    output logic        m_axis_tlast,     // out_last
    output logic [1:0]  m_axis_tuser      // out_valid, row_overflow
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int LW = $clog2(MAX_WIDTH + 1);
    localparam int SW = ((LW > 8) ? LW : 8) + 1;

    // Sample store.
    logic [7:0]    sample_mem [MAX_WIDTH];
    logic [7:0]    rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;

    state_t        state_reg, state_next;
    phase_t        phase_reg, phase_next;
    logic [LW-1:0] row_length_reg, row_length_next;
    logic [LW-1:0] read_pos_reg, read_pos_next;
    logic [6:0]    remaining_reg, remaining_next;
    logic          begun_reg, begun_next;
    logic          overflow_reg, overflow_next;
    logic [1:0]    channel_reg;
    logic [7:0]    iss_k_reg, iss_k_next;
    logic          rd_valid_reg, rd_valid_next;
    logic [7:0]    rd_k_reg;
    logic          rd_last_reg;
    logic          m_valid_reg, m_valid_next;

    logic [7:0]    res_byte_reg, res_byte_next;
    logic          res_last_reg, res_last_next;
    logic          res_ok_reg, res_ok_next;
    logic [7:0]    out_byte_reg;
    logic          out_last_reg;
    logic          out_ok_reg;
    logic          out_ovf_reg;
    logic          out_load;

    logic          s_fire;
    logic [7:0]    sample;
    logic [7:0]    iss_off;
    logic [SW-1:0] iss_sum;
    logic          issue;
    logic          issue_ok;
    logic          issue_last;
    logic [6:0]    rem_dec;
    scan_arr_t     arr;
    scan_dec_t     dec;

    assign s_fire        = s_axis_tvalid & s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = {out_ovf_reg, out_ok_reg};
    assign out_load      = (state_reg == ST_EMIT) & (~m_valid_reg | m_axis_tready);

    // Channel byte picked from the pixel.
    always_comb
    begin
        unique case (channel_reg)
            2'd0: sample = s_axis_tdata[7:0];
            2'd1: sample = s_axis_tdata[15:8];
            2'd2: sample = s_axis_tdata[23:16];
            2'd3: sample = s_axis_tdata[31:24];
        endcase
    end

    // Scan read address relative to the packet start.
    assign iss_off    = (state_reg == ST_IDLE) ? 8'd0 : iss_k_reg;
    assign iss_sum    = SW'(read_pos_reg) + SW'(iss_off);
    assign issue_ok   = (iss_sum < SW'(row_length_reg));
    assign issue_last = ((iss_sum + SW'(1)) >= SW'(row_length_reg));
    assign rem_dec    = remaining_reg - 7'd1;

    // Header scan evaluation.
    assign arr.valid  = rd_valid_reg & (state_reg == ST_SCAN);
    assign arr.offset = rd_k_reg;
    assign arr.last   = rd_last_reg;
    assign arr.data   = rd_data_reg;

    rlerc_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .arr   (arr),
        .dec   (dec)
    );

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        row_length_next = row_length_reg;
        read_pos_next   = read_pos_reg;
        remaining_next  = remaining_reg;
        begun_next      = begun_reg;
        overflow_next   = overflow_reg;
        iss_k_next      = iss_k_reg;
        res_byte_next   = res_byte_reg;
        res_last_next   = res_last_reg;
        res_ok_next     = res_ok_reg;
        m_valid_next    = m_valid_reg & ~m_axis_tready;
        mem_we          = 1'b0;
        wr_addr         = row_length_reg[AW-1:0];
        wr_data         = sample;
        rd_en           = 1'b0;
        rd_addr         = iss_sum[AW-1:0];
        issue           = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire && (s_axis_tuser[0] == OP_LOAD))
                begin
                    if (s_axis_tuser[1])
                    begin
                        // A new row starts with this pixel.
                        mem_we          = 1'b1;
                        wr_addr         = '0;
                        row_length_next = LW'(1);
                        read_pos_next   = '0;
                        phase_next      = PH_HEADER;
                        remaining_next  = 7'd0;
                        begun_next      = 1'b0;
                        overflow_next   = 1'b0;
                    end
                    else if (begun_reg || (row_length_reg >= LW'(MAX_WIDTH)))
                    begin
                        overflow_next = 1'b1;
                    end
                    else
                    begin
                        mem_we          = 1'b1;
                        row_length_next = row_length_reg + LW'(1);
                    end
                end
                else if (s_fire)
                begin
                    begun_next = 1'b1;
                    unique case (phase_reg)
                        PH_DONE:
                        begin
                            res_byte_next = 8'd0;
                            res_last_next = 1'b0;
                            res_ok_next   = 1'b0;
                            state_next    = ST_EMIT;
                        end
                        PH_HEADER:
                        begin
                            if (read_pos_reg >= row_length_reg)
                            begin
                                // Row terminator.
                                res_byte_next = 8'd0;
                                res_last_next = 1'b1;
                                res_ok_next   = 1'b1;
                                phase_next    = PH_DONE;
                                state_next    = ST_EMIT;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                issue      = 1'b1;
                                iss_k_next = 8'd1;
                                state_next = ST_SCAN;
                            end
                        end
                        PH_RUN_VALUE, PH_LITERAL:
                        begin
                            rd_en      = 1'b1;
                            state_next = ST_FETCH;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (dec.done)
                begin
                    res_last_next  = 1'b0;
                    res_ok_next    = 1'b1;
                    remaining_next = dec.count;
                    if (dec.is_run)
                    begin
                        res_byte_next = {1'b0, dec.count};
                        phase_next    = PH_RUN_VALUE;
                    end
                    else
                    begin
                        res_byte_next = LITERAL_FLAG | {1'b0, dec.count};
                        phase_next    = PH_LITERAL;
                    end
                    state_next = ST_EMIT;
                end
                else if (issue_ok)
                begin
                    rd_en      = 1'b1;
                    issue      = 1'b1;
                    iss_k_next = iss_k_reg + 8'd1;
                end
            end
            ST_FETCH:
            begin
                res_byte_next = rd_data_reg;
                res_last_next = 1'b0;
                res_ok_next   = 1'b1;
                if (phase_reg == PH_RUN_VALUE)
                begin
                    read_pos_next  = LW'({1'b0, read_pos_reg} + (LW+1)'(remaining_reg));
                    remaining_next = 7'd0;
                    phase_next     = PH_HEADER;
                end
                else
                begin
                    read_pos_next  = read_pos_reg + LW'(1);
                    remaining_next = rem_dec;
                    if (rem_dec == 7'd0)
                    begin
                        phase_next = PH_HEADER;
                    end
                end
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
        endcase

        rd_valid_next = issue;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            phase_reg      <= PH_HEADER;
            row_length_reg <= '0;
            read_pos_reg   <= '0;
            remaining_reg  <= 7'd0;
            begun_reg      <= 1'b0;
            overflow_reg   <= 1'b0;
            channel_reg    <= 2'd0;
            iss_k_reg      <= 8'd0;
            rd_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            row_length_reg <= row_length_next;
            read_pos_reg   <= read_pos_next;
            remaining_reg  <= remaining_next;
            begun_reg      <= begun_next;
            overflow_reg   <= overflow_next;
            iss_k_reg      <= iss_k_next;
            rd_valid_reg   <= rd_valid_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_wr_en)
            begin
                channel_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers: result staging, output stage and read tags.
    always_ff @(posedge clk)
    begin
        res_byte_reg <= res_byte_next;
        res_last_reg <= res_last_next;
        res_ok_reg   <= res_ok_next;
        if (issue)
        begin
            rd_k_reg    <= iss_off;
            rd_last_reg <= issue_last;
        end
        if (out_load)
        begin
            out_byte_reg <= res_byte_reg;
            out_last_reg <= res_last_reg;
            out_ok_reg   <= res_ok_reg;
            out_ovf_reg  <= overflow_reg;
        end
    end

    // Sample store write and registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sample_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= sample_mem[rd_addr];
        end
    end

    // Checks on the encoder state.
    `RLERC_ASSERT_NOW(a_pos_in_row, 1'b1, read_pos_reg <= row_length_reg)
    `RLERC_ASSERT_NOW(a_done_at_end, phase_reg == PH_DONE, read_pos_reg == row_length_reg)
    `RLERC_ASSERT_NOW(a_remaining_phase, 1'b1,
        ((phase_reg == PH_HEADER) || (phase_reg == PH_DONE)) == (remaining_reg == 7'd0))
    `RLERC_ASSERT_NEXT(a_read_busy, s_fire && (s_axis_tuser[0] == OP_READ), !s_axis_tready)

endmodule

// ----- rtl/rlerc_scan.sv -----
module rlerc_scan
    import rlerc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  scan_arr_t arr,
    output scan_dec_t dec
);

    logic [7:0] v0_reg;
    logic [7:0] w1_reg;
    logic [7:0] w2_reg;
    logic       running_reg;
    logic [6:0] runlen_reg;

    logic       first;
    logic       match;
    logic       run_after;
    logic [6:0] rl_new;
    logic       run_ends;
    logic       run_dec;
    logic       lit_dec;
    logic [6:0] lit_count;
    logic [7:0] lit_pos;
    logic [6:0] last_count;
    logic       triple;

    // Evaluate the incoming sample against the run and the sliding window.
    always_comb
    begin
        first      = (arr.offset == 8'd0);
        match      = (arr.data == v0_reg);
        run_after  = first | (running_reg & match);
        if (first)
        begin
            rl_new = 7'd1;
        end
        else if (running_reg & match)
        begin
            rl_new = runlen_reg + 7'd1;
        end
        else
        begin
            rl_new = runlen_reg;
        end
        run_ends   = (first | running_reg) & (~run_after | (rl_new == MAX_COUNT) | arr.last);
        run_dec    = run_ends & (rl_new >= MIN_RUN);

        // A literal stops before a run of three, at the count limit or at the row end.
        lit_pos    = arr.offset - 8'd2;
        triple     = (w2_reg == w1_reg) & (w1_reg == arr.data);
        last_count = (arr.offset >= ({1'b0, MAX_COUNT} - 8'd1)) ? MAX_COUNT
                                                                : 7'(arr.offset + 8'd1);
        lit_dec    = 1'b0;
        lit_count  = last_count;
        if (rl_new < MIN_RUN)
        begin
            if (arr.offset >= {1'b0, MIN_RUN})
            begin
                if (lit_pos >= {1'b0, MAX_COUNT})
                begin
                    lit_dec   = 1'b1;
                    lit_count = MAX_COUNT;
                end
                else if (triple)
                begin
                    lit_dec   = 1'b1;
                    lit_count = lit_pos[6:0];
                end
                else
                begin
                    lit_dec   = arr.last;
                end
            end
            else
            begin
                lit_dec = arr.last;
            end
        end

        dec.done   = arr.valid & (run_dec | lit_dec);
        dec.is_run = run_dec;
        dec.count  = run_dec ? rl_new : lit_count;
    end

    // Run tracking state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            runlen_reg  <= 7'd0;
        end
        else if (arr.valid)
        begin
            running_reg <= run_after;
            runlen_reg  <= rl_new;
        end
    end

    // Sample window, payload only.
    always_ff @(posedge clk)
    begin
        if (arr.valid)
        begin
            if (first)
            begin
                v0_reg <= arr.data;
            end
            w2_reg <= w1_reg;
            w1_reg <= arr.data;
        end
    end

endmodule
